// ===== hw/rtl/boxf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boxf_pkg: shared types and constants of the 3x3 box mean filter
// Pixel and sum widths, register indexes, controller states, the result
// record and the reciprocal table used for the normalizing divide.
// ----------------------------------------------------------------------------
package boxf_pkg;

  localparam int PIXEL_BITS    = 8;
  localparam int COL_SUM_BITS  = PIXEL_BITS + 2;
  localparam int SUM_BITS      = PIXEL_BITS + 4;
  localparam int CNT_BITS      = 4;
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam int MAX_HEIGHT    = 4096;
  localparam int WIDTH_RESET   = 1024;
  localparam int HEIGHT_RESET  = 4096;
  localparam int RECIP_SHIFT   = 20;
  localparam int RECIP_BITS    = RECIP_SHIFT + 1;

  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_BITS'(1);

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_FL1,
    ST_FL2,
    ST_FL3,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] smoothed;
    logic                  end_of_row;
    logic                  end_of_image;
    logic                  last_of_run;
  } res_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] cnt;
    logic                end_of_row;
    logic                end_of_image;
  } pend_t;

  // Rounded-up reciprocals, scaled by 2**RECIP_SHIFT. Exact floors for any
  // sum of up to nine pixels.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    case (cnt)
      CNT_BITS'(1): r = RECIP_BITS'(1048576);
      CNT_BITS'(2): r = RECIP_BITS'(524288);
      CNT_BITS'(3): r = RECIP_BITS'(349526);
      CNT_BITS'(4): r = RECIP_BITS'(262144);
      CNT_BITS'(6): r = RECIP_BITS'(174763);
      CNT_BITS'(9): r = RECIP_BITS'(116509);
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/boxf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boxf_ram: line store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module boxf_ram #(
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/boxf_mean.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boxf_mean: normalizing divide
// Floor of sum / count by multiplication with a scaled reciprocal.
// ----------------------------------------------------------------------------
module boxf_mean
  import boxf_pkg::*;
(
  input  logic [SUM_BITS-1:0]   sum_i,
  input  logic [CNT_BITS-1:0]   cnt_i,
  output logic [PIXEL_BITS-1:0] mean_o
);

  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

  logic [PROD_BITS-1:0] prod;

  assign prod   = PROD_BITS'(sum_i) * PROD_BITS'(recip(cnt_i));
  assign mean_o = prod[RECIP_SHIFT +: PIXEL_BITS];

endmodule
`default_nettype wire

// ===== hw/rtl/boxf_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boxf_outq: two-entry result queue
// Holds the one or two results of an item until the receiver takes them.
// ----------------------------------------------------------------------------
module boxf_outq
  import boxf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push_a,
  input  res_t       push_b,
  input  logic       out_ready,
  output logic       out_valid,
  output res_t       out_head,
  output logic [1:0] room
);

  res_t       q0_r, q0_nxt;
  res_t       q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_pop;
  logic       pop;

  always_comb begin
    pop     = (cnt_r != 2'd0) && out_ready;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_pop = cnt_r;
    if (pop) begin
      q0_nxt  = q1_r;
      cnt_pop = cnt_r - 2'd1;
    end
    // The controller only pushes what fits, so the queue never overflows.
    if (push_n != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        q0_nxt = push_a;
        q1_nxt = push_b;
      end else begin
        q1_nxt = push_a;
      end
    end
    cnt_nxt = cnt_pop + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_head  = q0_r;
  assign room      = 2'd2 - cnt_r;

endmodule
`default_nettype wire

// ===== hw/rtl/box_filter_3x3_edge_normalized_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_normalized_top: streaming 3x3 box mean filter
// Raster-order pixels in, floor means over the in-image neighborhood out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per pixel (in_tuser = 0) or flush tick (in_tuser = 1).
//   out_* : smoothed pixel in out_tdata; out_tuser flags row and image end;
//           out_tlast marks the final result of one input request.
//   cfg_* : image width (index 0) and height (index 1); a write restarts the
//           image. Write only while the block is idle.
// Results run one row behind the input; after the last pixel, one flush
// request per column drains the final row.
// Timing: a pixel request occupies the block through accept with line store
// read (ST_IDLE), compute and write back (ST_PIX) and push to the output
// queue (ST_EMIT); a flush request runs through ST_IDLE, ST_FL1, ST_FL2,
// ST_FL3 and ST_EMIT, since its three neighbor columns are read one per
// cycle through the single read port. Ignored requests are taken and dropped.
// A two-entry output queue lets the next request be accepted while results
// wait; if the receiver stalls, the block holds in its push state until room
// opens. Reset clears counters and the queue; the line store needs no clear.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_normalized_top
  import boxf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] pixel_in
  input  logic                     in_tuser,   // [0] mode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,  // [7:0] smoothed
  output logic [1:0]               out_tuser,  // [0] end_of_row, [1] end_of_image
  output logic                     out_tlast,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WIDTH_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int HEIGHT_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
  localparam int MEM_BITS = 2 * PIXEL_BITS;

  state_t                   state_r, state_nxt;
  logic [WIDTH_BITS-1:0]    width_r, width_nxt;
  logic [HEIGHT_BITS-1:0]   height_r, height_nxt;
  logic [WIDTH_BITS-1:0]    col_r, col_nxt;
  logic [HEIGHT_BITS-1:0]   row_r, row_nxt;
  logic [WIDTH_BITS-1:0]    drain_r, drain_nxt;
  logic                     draining_r, draining_nxt;
  logic [COL_SUM_BITS-1:0]  csw0_r, csw0_nxt;
  logic [COL_SUM_BITS-1:0]  csw1_r, csw1_nxt;
  logic [PIXEL_BITS-1:0]    pix_r, pix_nxt;
  pend_t                    pend0_r, pend0_nxt;
  pend_t                    pend1_r, pend1_nxt;
  logic [1:0]               pend_n_r, pend_n_nxt;

  logic                     rd_en, wr_en;
  logic [ADDR_BITS-1:0]     rd_addr;
  logic [MEM_BITS-1:0]      rd_data, wr_data;
  logic [PIXEL_BITS-1:0]    mem_top, mem_mid;

  logic                     pix_top_v, lv1, lv2, last_col, last_row, has_a, has_b;
  logic [COL_SUM_BITS-1:0]  cs_new, fcs;
  logic [SUM_BITS-1:0]      sum_a, sum_b, sum_f;
  logic [CNT_BITS-1:0]      rows_pix, cnt_a, cnt_b, cnt_f, cols_f;
  logic                     fl_top_v, fl_lv, fl_rv;

  logic [1:0]               push_n, q_room;
  logic [PIXEL_BITS-1:0]    mean_a, mean_b;
  res_t                     push_a, push_b, head;
  logic [WIDTH_BITS-1:0]    cfg_w;
  logic [HEIGHT_BITS-1:0]   cfg_h;

  // Each entry holds one column: {row two back, previous row}.
  boxf_ram #(
    .DEPTH     (MAX_WIDTH),
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (MEM_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_BITS'(col_r)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign mem_top = rd_data[MEM_BITS-1:PIXEL_BITS];
  assign mem_mid = rd_data[PIXEL_BITS-1:0];

  // Pixel path: column sums of the window; the top row is dropped on row 1.
  assign pix_top_v = (row_r >= HEIGHT_BITS'(2));
  assign lv1       = (col_r >= WIDTH_BITS'(2));
  assign lv2       = (col_r != '0);
  assign last_col  = (col_r == width_r - WIDTH_BITS'(1));
  assign last_row  = (row_r == height_r - HEIGHT_BITS'(1));
  assign has_a     = (row_r != '0) && lv2;
  assign has_b     = (row_r != '0) && last_col;
  assign cs_new    = COL_SUM_BITS'(pix_top_v ? mem_top : '0) + COL_SUM_BITS'(mem_mid)
                   + COL_SUM_BITS'(pix_r);
  assign rows_pix  = pix_top_v ? CNT_BITS'(3) : CNT_BITS'(2);
  assign sum_a     = SUM_BITS'(lv1 ? csw0_r : '0) + SUM_BITS'(csw1_r) + SUM_BITS'(cs_new);
  assign cnt_a     = rows_pix * (lv1 ? CNT_BITS'(3) : CNT_BITS'(2));
  assign sum_b     = SUM_BITS'(lv2 ? csw1_r : '0) + SUM_BITS'(cs_new);
  assign cnt_b     = rows_pix * (lv2 ? CNT_BITS'(2) : CNT_BITS'(1));

  // Drain path: the bottom row lies outside the image.
  assign fl_top_v = (height_r >= HEIGHT_BITS'(2));
  assign fl_lv    = (drain_r != '0);
  assign fl_rv    = (drain_r != width_r - WIDTH_BITS'(1));
  assign fcs      = COL_SUM_BITS'(fl_top_v ? mem_top : '0) + COL_SUM_BITS'(mem_mid);
  assign sum_f    = SUM_BITS'(fl_lv ? csw0_r : '0) + SUM_BITS'(csw1_r)
                  + SUM_BITS'(fl_rv ? fcs : '0);
  assign cols_f   = CNT_BITS'(1) + CNT_BITS'(fl_lv) + CNT_BITS'(fl_rv);
  assign cnt_f    = (fl_top_v ? CNT_BITS'(2) : CNT_BITS'(1)) * cols_f;

  // Register values as written, with zero taken as one and saturation.
  always_comb begin
    cfg_w = cfg_wdata[WIDTH_BITS-1:0];
    if (cfg_w == '0) begin
      cfg_w = WIDTH_BITS'(1);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      cfg_w = WIDTH_BITS'(MAX_WIDTH);
    end
    cfg_h = cfg_wdata[HEIGHT_BITS-1:0];
    if (cfg_h == '0) begin
      cfg_h = HEIGHT_BITS'(1);
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      cfg_h = HEIGHT_BITS'(MAX_HEIGHT);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    drain_nxt    = drain_r;
    draining_nxt = draining_r;
    csw0_nxt     = csw0_r;
    csw1_nxt     = csw1_r;
    pix_nxt      = pix_r;
    pend0_nxt    = pend0_r;
    pend1_nxt    = pend1_r;
    pend_n_nxt   = pend_n_r;
    rd_en        = 1'b0;
    rd_addr      = ADDR_BITS'(col_r);
    wr_en        = 1'b0;
    wr_data      = {mem_mid, pix_r};
    push_n       = 2'd0;
    in_tready    = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          pix_nxt = in_tdata[PIXEL_BITS-1:0];
          if (in_tuser == MODE_PIXEL && !draining_r) begin
            rd_en     = 1'b1;
            rd_addr   = ADDR_BITS'(col_r);
            state_nxt = ST_PIX;
          end else if (in_tuser == MODE_FLUSH && draining_r) begin
            rd_en     = 1'b1;
            rd_addr   = ADDR_BITS'(drain_r - WIDTH_BITS'(1));
            state_nxt = ST_FL1;
          end
        end
      end
      ST_PIX: begin
        // Read-modify-write of the column; the next read can only come from the idle
        // state after the push state, so a one-pixel-wide image still sees the new value.
        wr_en    = 1'b1;
        csw0_nxt = csw1_r;
        csw1_nxt = cs_new;
        if (has_a) begin
          pend0_nxt = '{sum: sum_a, cnt: cnt_a, end_of_row: 1'b0, end_of_image: 1'b0};
        end else begin
          pend0_nxt = '{sum: sum_b, cnt: cnt_b, end_of_row: 1'b1, end_of_image: 1'b0};
        end
        pend1_nxt  = '{sum: sum_b, cnt: cnt_b, end_of_row: 1'b1, end_of_image: 1'b0};
        pend_n_nxt = 2'(has_a) + 2'(has_b);
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            row_nxt      = '0;
            draining_nxt = 1'b1;
            drain_nxt    = '0;
          end else begin
            row_nxt = row_r + HEIGHT_BITS'(1);
          end
        end else begin
          col_nxt = col_r + WIDTH_BITS'(1);
        end
        state_nxt = ST_EMIT;
      end
      ST_FL1: begin
        rd_en     = 1'b1;
        rd_addr   = ADDR_BITS'(drain_r);
        csw0_nxt  = csw1_r;
        csw1_nxt  = fcs;
        state_nxt = ST_FL2;
      end
      ST_FL2: begin
        rd_en     = 1'b1;
        rd_addr   = ADDR_BITS'(drain_r + WIDTH_BITS'(1));
        csw0_nxt  = csw1_r;
        csw1_nxt  = fcs;
        state_nxt = ST_FL3;
      end
      ST_FL3: begin
        pend0_nxt  = '{sum: sum_f, cnt: cnt_f, end_of_row: !fl_rv, end_of_image: !fl_rv};
        pend_n_nxt = 2'd1;
        if (!fl_rv) begin
          drain_nxt    = '0;
          draining_nxt = 1'b0;
          col_nxt      = '0;
          row_nxt      = '0;
          csw0_nxt     = '0;
          csw1_nxt     = '0;
        end else begin
          drain_nxt = drain_r + WIDTH_BITS'(1);
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (pend_n_r <= q_room) begin
          push_n    = pend_n_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A register write restarts the image; the line store keeps its data.
    if (cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT)) begin
      if (cfg_addr == REG_IMAGE_WIDTH) begin
        width_nxt = cfg_w;
      end else begin
        height_nxt = cfg_h;
      end
      col_nxt      = '0;
      row_nxt      = '0;
      drain_nxt    = '0;
      draining_nxt = 1'b0;
      csw0_nxt     = '0;
      csw1_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_BITS'(WIDTH_RST);
      height_r   <= HEIGHT_BITS'(HEIGHT_RST);
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      draining_r <= 1'b0;
      csw0_r     <= '0;
      csw1_r     <= '0;
      pend_n_r   <= 2'd0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      drain_r    <= drain_nxt;
      draining_r <= draining_nxt;
      csw0_r     <= csw0_nxt;
      csw1_r     <= csw1_nxt;
      pend_n_r   <= pend_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r   <= pix_nxt;
    pend0_r <= pend0_nxt;
    pend1_r <= pend1_nxt;
  end

  boxf_mean u_mean_a (
    .sum_i  (pend0_r.sum),
    .cnt_i  (pend0_r.cnt),
    .mean_o (mean_a)
  );

  boxf_mean u_mean_b (
    .sum_i  (pend1_r.sum),
    .cnt_i  (pend1_r.cnt),
    .mean_o (mean_b)
  );

  assign push_a = '{smoothed: mean_a, end_of_row: pend0_r.end_of_row,
                    end_of_image: pend0_r.end_of_image, last_of_run: (pend_n_r == 2'd1)};
  assign push_b = '{smoothed: mean_b, end_of_row: pend1_r.end_of_row,
                    end_of_image: pend1_r.end_of_image, last_of_run: 1'b1};

  boxf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_head  (head),
    .room      (q_room)
  );

  assign out_tdata = head.smoothed;
  assign out_tuser = {head.end_of_image, head.end_of_row};
  assign out_tlast = head.last_of_run;

  // While the last row drains, the raster position sits at the image start.
  a_drain_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (col_r == '0 && row_r == '0))
    else $error("drain active away from the image origin");

  a_drain_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r < width_r)
    else $error("drain position beyond the row width");

  a_pixel_to_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == MODE_PIXEL && !draining_r && !cfg_we)
      |=> state_r == ST_PIX)
    else $error("accepted pixel request did not start its read-modify-write");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && pend_n_r != 2'd0 && pend_n_r <= q_room) |=> out_tvalid)
    else $error("pushed result not presented on the output");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the streaming 3x3 box mean filter
// Drives pixel and flush requests with random gaps and output stalls. A
// behavioral model of the line stores, column window and edge-normalized
// mean predicts every result, which the checker compares field by field
// against the output stream. It covers corner images, many small random
// images, abandoned images and out-of-range register values.
// ----------------------------------------------------------------------------
module tb_top
  import boxf_pkg::*;
();

  localparam int     LINE_LEN      = 1024;
  localparam int     SETTLE_CYCLES = 12;
  localparam longint CYCLE_LIMIT   = 2_000_000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = '0;   // [7:0] pixel_in
  logic                     in_tuser   = 1'b0; // [0] mode
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [7:0]               out_tdata;         // [7:0] smoothed
  logic [1:0]               out_tuser;         // [0] end_of_row, [1] end_of_image
  logic                     out_tlast;
  logic                     cfg_we     = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;

  int     sender_gap_pct  = 33;
  int     stall_pct       = 85;
  int     mismatch_count  = 0;
  int     results_checked = 0;
  int     requests_sent   = 0;
  int     stream_items    = 0;
  int     images_drained  = 0;
  int     reg_writes      = 0;
  longint cycle_count     = 0;

  // Filter model state
  logic [7:0]  row_above2 [LINE_LEN];
  logic [7:0]  row_above1 [LINE_LEN];
  logic [23:0] nbhd [3];
  int unsigned col_pos, row_pos, drain_pos, img_w, img_h;
  bit          draining;
  res_t        pending_means [$];

  box_filter_3x3_edge_normalized_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_means.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------- model --

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void restart_image();
    for (int i = 0; i < 3; i++) nbhd[i] = '0;
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
    draining  = 1'b0;
  endfunction

  // Columns hold {top, middle, bottom}; excluded rows and columns drop out of
  // both the sum and the divisor.
  function automatic logic [7:0] box_average(input logic [23:0] lc, input logic [23:0] mc,
                                             input logic [23:0] rc, input bit lv,
                                             input bit rv, input bit tv, input bit bv);
    int unsigned       sum;
    int unsigned       cnt;
    logic [2:0][23:0]  cols;
    sum  = 0;
    cnt  = 0;
    cols = {rc, mc, lc};
    for (int c = 0; c < 3; c++) begin
      if ((c == 0 && !lv) || (c == 2 && !rv)) continue;
      for (int r = 0; r < 3; r++) begin
        if ((r == 0 && !tv) || (r == 2 && !bv)) continue;
        sum += cols[c][(2 - r) * 8 +: 8];
        cnt++;
      end
    end
    return (cnt != 0) ? 8'(sum / cnt) : 8'd0;
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    if (idx == REG_IMAGE_WIDTH) img_w = clamp_dim(val[WIDTH_BITS-1:0], LINE_LEN);
    else                        img_h = clamp_dim(val, MAX_HEIGHT);
    restart_image();
  endfunction

  function automatic void predict_request(input mode_t m, input logic [7:0] px);
    res_t        found [2];
    int          n;
    logic [7:0]  above2, above1;
    logic [23:0] lc, mc, rc;
    bit          last;
    n = 0;
    if (m == MODE_PIXEL) begin
      if (draining || col_pos >= img_w) return;
      above2 = row_above2[col_pos];
      above1 = row_above1[col_pos];
      row_above2[col_pos] = above1;
      row_above1[col_pos] = px;
      nbhd[0] = nbhd[1];
      nbhd[1] = nbhd[2];
      nbhd[2] = {above2, above1, px};
      // Output lags one row and one column behind the arriving pixel.
      if (row_pos >= 1) begin
        if (col_pos >= 1) begin
          found[n] = '{smoothed: box_average(nbhd[0], nbhd[1], nbhd[2], col_pos >= 2, 1'b1,
                                             row_pos >= 2, 1'b1),
                       end_of_row: 1'b0, end_of_image: 1'b0, last_of_run: 1'b0};
          n++;
        end
        if (col_pos == img_w - 1) begin
          found[n] = '{smoothed: box_average(nbhd[1], nbhd[2], 24'h0, col_pos >= 1, 1'b0,
                                             row_pos >= 2, 1'b1),
                       end_of_row: 1'b1, end_of_image: 1'b0, last_of_run: 1'b0};
          n++;
        end
      end
      col_pos++;
      if (col_pos >= img_w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= img_h) begin
          row_pos   = 0;
          draining  = 1'b1;
          drain_pos = 0;
        end
      end
    end else begin
      if (!draining || drain_pos >= img_w) return;
      lc = '0;
      rc = '0;
      if (drain_pos >= 1)
        lc = {row_above2[drain_pos - 1], row_above1[drain_pos - 1], 8'h00};
      mc = {row_above2[drain_pos], row_above1[drain_pos], 8'h00};
      if (drain_pos + 1 < img_w)
        rc = {row_above2[drain_pos + 1], row_above1[drain_pos + 1], 8'h00};
      last = (drain_pos == img_w - 1);
      found[0] = '{smoothed: box_average(lc, mc, rc, drain_pos >= 1, drain_pos + 1 < img_w,
                                         img_h >= 2, 1'b0),
                   end_of_row: last, end_of_image: last, last_of_run: 1'b0};
      n = 1;
      drain_pos++;
      if (drain_pos >= img_w) begin
        restart_image();
        images_drained++;
      end
    end
    if (n > 0) found[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_means.push_back(found[i]);
  endfunction

  // -------------------------------------------------------------- checker --

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual smoothed %0d tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        want = pending_means.pop_front();
        if (out_tdata !== want.smoothed)
          report_field("smoothed", want.smoothed, out_tdata);
        if (out_tuser[0] !== want.end_of_row)
          report_field("end_of_row", want.end_of_row, out_tuser[0]);
        if (out_tuser[1] !== want.end_of_image)
          report_field("end_of_image", want.end_of_image, out_tuser[1]);
        if (out_tlast !== want.last_of_run)
          report_field("last_of_run", want.last_of_run, out_tlast);
      end
    end
  end

  // -------------------------------------------------------------- drivers --

  task automatic send_req(input mode_t m, input logic [7:0] px);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    predict_request(m, px);
  endtask

  // Hold off until every predicted result is out and the block is quiet.
  task automatic wait_for_quiet();
    in_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'd255;
    if (r < 25) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  // Sends pixels of the current image, then optionally drains its last row.
  // With noise on, stray flushes, pauses and stray pixels are mixed in.
  task automatic send_image(input int unsigned n_pix, input bit do_drain, input bit noisy);
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(99) < 3) send_req(MODE_FLUSH, 8'($urandom_range(255)));
      if (noisy && $urandom_range(99) < 2) wait_for_quiet();
      send_req(MODE_PIXEL, pick_pixel());
      stream_items++;
    end
    if (do_drain) begin
      if (noisy && draining && $urandom_range(99) < 20) send_req(MODE_PIXEL, pick_pixel());
      for (int unsigned k = 0; k < img_w; k++) begin
        send_req(MODE_FLUSH, 8'($urandom_range(255)));
        stream_items++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests --

  // Reset dimensions: one full 1024-wide row, then the start of the next.
  task automatic test_reset_dims();
    send_req(MODE_FLUSH, 8'd255);
    send_image(LINE_LEN + 4, 1'b0, 1'b0);
  endtask

  task automatic test_corner_images();
    wait_for_quiet();
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    send_req(MODE_FLUSH, 8'd0);
    send_req(MODE_PIXEL, 8'd255);
    send_req(MODE_PIXEL, 8'd0);
    send_req(MODE_FLUSH, 8'd0);
    send_req(MODE_PIXEL, 8'd0);
    send_req(MODE_FLUSH, 8'd255);
    wait_for_quiet();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_req(MODE_FLUSH, 8'd255);
      send_req(MODE_PIXEL, (i == 7) ? 8'd0 : 8'd255);
    end
    for (int k = 0; k < 3; k++) send_req(MODE_FLUSH, 8'd0);
  endtask

  task automatic test_random_stream(input int target);
    int          goal;
    int unsigned w_raw, h_raw, pix_total, n_pix;
    bit          cut_short, fresh;
    goal  = stream_items + target;
    fresh = 1'b0;
    while (stream_items < goal) begin
      wait_for_quiet();
      if (!fresh || $urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0:       w_raw = 0;
          1:       w_raw = $urandom_range(41, 80);
          2, 3:    w_raw = $urandom_range(9, 32);
          default: w_raw = $urandom_range(1, 8);
        endcase
        if ($urandom_range(19) == 0) h_raw = 0;
        else                         h_raw = (w_raw > 32) ? $urandom_range(1, 3)
                                                          : $urandom_range(1, 7);
        // Bits above the width field must be dropped by the block.
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w_raw | ($urandom_range(3) << WIDTH_BITS)));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h_raw));
      end
      pix_total = img_w * img_h;
      cut_short = ($urandom_range(9) == 0);
      n_pix     = cut_short ? $urandom_range(0, pix_total - 1) : pix_total;
      send_image(n_pix, !cut_short, 1'b1);
      fresh = !cut_short;
    end
  endtask

  // Width with stray high bits and an oversized height, then a one-pixel-wide
  // column that runs well past the rows a small height would allow.
  task automatic test_extreme_dims();
    wait_for_quiet();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(13'h1801));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(13'h1FFF));
    send_image(48, 1'b0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < LINE_LEN; i++) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    img_w = WIDTH_RESET;
    img_h = HEIGHT_RESET;
    restart_image();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_dims();
    test_corner_images();
    test_random_stream(200);
    sender_gap_pct = 85;
    stall_pct      = 33;
    test_random_stream(200);
    sender_gap_pct = 0;
    stall_pct      = 0;
    test_random_stream(200);
    test_extreme_dims();
    wait_for_quiet();

    $display("Sent %0d requests over %0d register writes; %0d images fully drained.",
             requests_sent, reg_writes, images_drained);
    $display("Checked %0d results, widths 1 to 1024 and heights 1 to 4096.",
             results_checked);
    if (mismatch_count == 0 && pending_means.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
